### design/pcen_pkg.sv
// pcen_pkg: widths, constants and controller/datapath handoff types for the
// polygon centroid block. No dependencies.
package pcen_pkg;

   localparam int COORD_W          = 16;   // Q12.4 vertex and result
   localparam int LIMIT_W          = 16;   // zero-area limit register
   localparam int REL_W            = 17;   // vertex relative to origin
   localparam int PROD_W           = 2 * REL_W;
   localparam int CROSS_W          = PROD_W + 1;
   localparam int PSUM_W           = REL_W + 1;
   localparam int MPROD_W          = PSUM_W + CROSS_W;
   localparam int AREA_W           = 45;   // doubled area, Q8
   localparam int MOM_W            = 63;   // first moments, Q12
   localparam int CENTROID_DIV     = 3;
   localparam int DEN_W            = AREA_W + 2;
   localparam int MAG_W            = MOM_W + 1;
   localparam int Q_W              = 18;   // quotient bits kept before saturation
   localparam int DVS_W            = DEN_W + 1 + Q_W;
   localparam int STEP_W           = $clog2(Q_W);
   localparam int RES_W            = Q_W + 2;
   localparam int DEF_MAX_VERTICES = 1024;

   typedef struct packed {
      logic take;       // input word may be accepted
      logic latch;      // pick divide operands, fallback decision
      logic prep;       // form divider magnitudes
      logic clear;      // clear polygon accumulators
      logic check;      // quotient range check, load divider
      logic step;       // one restoring divide step
      logic load_out;   // load result into output register
   } pcen_cmd_type;

   typedef struct packed {
      logic pipe_busy;  // a vertex is still in the cross-product pipe
      logic out_free;   // output register can take a new result
   } pcen_stat_type;

endpackage

### design/polygon_centroid_top.sv
// After the last vertex is taken the 4-stage cross-product pipe drains, then
// setup (operand pick, magnitudes, range check), the divide steps and the load.
// Throughput: one vertex per cycle inside a polygon; after the last vertex the
// input stays held off until the result is loaded, later while a word is stalled.
// Reset (synchronous, active high) clears all accumulators, the limit and the
// output valid.
module polygon_centroid_top import pcen_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2*COORD_W-1:0] req_tdata,   // vertex_x [15:0], vertex_y [31:16]
   input  logic                 req_tlast,   // last_vertex
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*COORD_W-1:0] rsp_tdata,   // centroid_x [15:0], centroid_y [31:16]
   output logic                 rsp_tuser,   // used_average
   input  logic                 csr_wr_en,
   input  logic [LIMIT_W-1:0]   csr_wr_data  // area_zero_limit
);

   pcen_cmd_type  cmd;
   pcen_stat_type stat;

   pcen_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcen_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

### design/pcen_ctrl.sv
// pcen_ctrl: sequencer for the polygon centroid block. Runs the vertex
// phase, drains the pipe and steps the shared divider. Uses pcen_pkg.
module pcen_ctrl import pcen_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   output logic          req_tready,
   input  pcen_stat_type stat,
   output pcen_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_RUN    = 7'b0000001,
      ST_DRAIN  = 7'b0000010,
      ST_PREP1  = 7'b0000100,
      ST_PREP2  = 7'b0001000,
      ST_CHECK  = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_RUN: begin
            cmd.take = 1'b1;
            if (req_tvalid && req_tlast) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_PREP1;
         end
         ST_PREP1: begin
            cmd.latch = 1'b1;
            state_in  = ST_PREP2;
         end
         ST_PREP2: begin
            cmd.prep  = 1'b1;
            cmd.clear = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            step_in   = STEP_W'(Q_W - 1);
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (step_ff == '0) state_in = ST_DONE;
            else step_in = step_ff - 1'b1;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign req_tready = cmd.take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### design/pcen_dpath.sv
// pcen_dpath: vertex pipe (relative coords, cross product, moments),
// accumulators, restoring divider for x and y, output register. Uses pcen_pkg.
module pcen_dpath import pcen_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pcen_cmd_type         cmd,
   output pcen_stat_type        stat,
   input  logic                 req_tvalid,
   input  logic [2*COORD_W-1:0] req_tdata,
   input  logic                 csr_wr_en,
   input  logic [LIMIT_W-1:0]   csr_wr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*COORD_W-1:0] rsp_tdata,
   output logic                 rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W = COORD_W + 1 + $clog2(MAX_VERTICES);

   function automatic logic [COORD_W-1:0] sat16(input logic signed [RES_W:0] v);
      logic [COORD_W-1:0] r;
      if (v > (RES_W+1)'(signed'(2**(COORD_W-1) - 1)))
         r = {1'b0, {(COORD_W-1){1'b1}}};
      else if (v < -(RES_W+1)'(signed'(2**(COORD_W-1))))
         r = {1'b1, {(COORD_W-1){1'b0}}};
      else
         r = v[COORD_W-1:0];
      return r;
   endfunction

   logic [LIMIT_W-1:0] limit_ff;

   // ---------------- vertex front end ----------------
   logic signed [COORD_W-1:0] vx, vy;
   logic signed [REL_W-1:0]   rx, ry;
   logic                      take, room, first;

   logic signed [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic signed [REL_W-1:0]   prev_x_ff, prev_y_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [SUM_W-1:0]   csum_x_ff, csum_y_ff;

   assign vx    = signed'(req_tdata[COORD_W-1:0]);
   assign vy    = signed'(req_tdata[2*COORD_W-1:COORD_W]);
   assign rx    = REL_W'(vx) - REL_W'(origin_x_ff);
   assign ry    = REL_W'(vy) - REL_W'(origin_y_ff);
   assign take  = cmd.take && req_tvalid;
   assign room  = cnt_ff < CNT_W'(MAX_VERTICES);
   assign first = (cnt_ff == '0);

   // pipe stages: 1 relative pair, 2 products, 3 cross, 4 moment products
   logic                      s1v_ff, s2v_ff, s3v_ff, s4v_ff;
   logic signed [REL_W-1:0]   s1_rx_ff, s1_ry_ff, s1_px_ff, s1_py_ff;
   logic signed [PROD_W-1:0]  s2_p1_ff, s2_p2_ff;
   logic signed [PSUM_W-1:0]  s2_sx_ff, s2_sy_ff, s3_sx_ff, s3_sy_ff;
   logic signed [CROSS_W-1:0] s3_t_ff, s4_t_ff;
   logic signed [MPROD_W-1:0] s4_mx_ff, s4_my_ff;
   logic signed [PROD_W-1:0]  p1_in, p2_in;
   logic signed [MPROD_W-1:0] mx_in, my_in;

   logic signed [AREA_W-1:0]  area_ff;
   logic signed [MOM_W-1:0]   mom_x_ff, mom_y_ff;

   assign p1_in = s1_px_ff * s1_ry_ff;
   assign p2_in = s1_rx_ff * s1_py_ff;
   assign mx_in = s3_sx_ff * s3_t_ff;
   assign my_in = s3_sy_ff * s3_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         cnt_ff      <= '0;
         csum_x_ff   <= '0;
         csum_y_ff   <= '0;
      end else if (take && room) begin
         cnt_ff    <= cnt_ff + 1'b1;
         csum_x_ff <= csum_x_ff + SUM_W'(vx);
         csum_y_ff <= csum_y_ff + SUM_W'(vy);
         if (first) begin
            origin_x_ff <= vx;
            origin_y_ff <= vy;
            prev_x_ff   <= '0;
            prev_y_ff   <= '0;
         end else begin
            prev_x_ff <= rx;
            prev_y_ff <= ry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff <= 1'b0;
         s2v_ff <= 1'b0;
         s3v_ff <= 1'b0;
         s4v_ff <= 1'b0;
      end else begin
         s1v_ff <= take && room && !first;
         s2v_ff <= s1v_ff;
         s3v_ff <= s2v_ff;
         s4v_ff <= s3v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_rx_ff <= rx;
      s1_ry_ff <= ry;
      s1_px_ff <= prev_x_ff;
      s1_py_ff <= prev_y_ff;
      s2_p1_ff <= p1_in;
      s2_p2_ff <= p2_in;
      s2_sx_ff <= PSUM_W'(s1_px_ff) + PSUM_W'(s1_rx_ff);
      s2_sy_ff <= PSUM_W'(s1_py_ff) + PSUM_W'(s1_ry_ff);
      s3_t_ff  <= CROSS_W'(s2_p1_ff) - CROSS_W'(s2_p2_ff);
      s3_sx_ff <= s2_sx_ff;
      s3_sy_ff <= s2_sy_ff;
      s4_t_ff  <= s3_t_ff;
      s4_mx_ff <= mx_in;
      s4_my_ff <= my_in;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         area_ff  <= '0;
         mom_x_ff <= '0;
         mom_y_ff <= '0;
      end else if (s4v_ff) begin
         area_ff  <= area_ff + AREA_W'(s4_t_ff);
         mom_x_ff <= mom_x_ff + MOM_W'(s4_mx_ff);
         mom_y_ff <= mom_y_ff + MOM_W'(s4_my_ff);
      end
   end

   assign stat.pipe_busy = s1v_ff | s2v_ff | s3v_ff | s4v_ff;

   // ---------------- operand selection ----------------
   logic [AREA_W-1:0]         area_mag;
   logic                      fb_in, fb_ff;
   logic signed [DEN_W-1:0]   den3, den_ff;
   logic signed [MOM_W-1:0]   num_x_ff, num_y_ff;
   logic signed [COORD_W-1:0] add_x_ff, add_y_ff;

   assign area_mag = area_ff[AREA_W-1] ? AREA_W'(-area_ff) : AREA_W'(area_ff);
   assign fb_in    = (cnt_ff < CNT_W'(CENTROID_DIV)) ||
                     (area_mag <= AREA_W'(limit_ff));
   assign den3     = (DEN_W'(area_ff) <<< 1) + DEN_W'(area_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         fb_ff <= fb_in;
         if (fb_in) begin
            num_x_ff <= MOM_W'(csum_x_ff);
            num_y_ff <= MOM_W'(csum_y_ff);
            den_ff   <= signed'(DEN_W'(cnt_ff));
            add_x_ff <= '0;
            add_y_ff <= '0;
         end else begin
            num_x_ff <= mom_x_ff;
            num_y_ff <= mom_y_ff;
            den_ff   <= den3;
            add_x_ff <= origin_x_ff;
            add_y_ff <= origin_y_ff;
         end
      end
   end

   // ---------------- divider ----------------
   // round(n/d) = floor((2|n| + |d|) / (2|d|)), sign applied after
   logic [MAG_W-1:0]   nx_ext, ny_ext, nx_mag, ny_mag;
   logic [DEN_W-1:0]   d_mag;
   logic [MAG_W-1:0]   nmag_x_ff, nmag_y_ff;
   logic [DEN_W:0]     dmag_ff;
   logic               neg_x_ff, neg_y_ff, ovf_x_ff, ovf_y_ff;
   logic [MAG_W-1:0]   rem_x_ff, rem_y_ff;
   logic [DVS_W-1:0]   dsh_ff;
   logic [Q_W-1:0]     q_x_ff, q_y_ff;
   logic               ge_x, ge_y;

   assign nx_ext = MAG_W'(num_x_ff);
   assign ny_ext = MAG_W'(num_y_ff);
   assign nx_mag = nx_ext[MAG_W-1] ? -nx_ext : nx_ext;
   assign ny_mag = ny_ext[MAG_W-1] ? -ny_ext : ny_ext;
   assign d_mag  = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
   assign ge_x   = DVS_W'(rem_x_ff) >= dsh_ff;
   assign ge_y   = DVS_W'(rem_y_ff) >= dsh_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         nmag_x_ff <= (nx_mag << 1) + MAG_W'(d_mag);
         nmag_y_ff <= (ny_mag << 1) + MAG_W'(d_mag);
         dmag_ff   <= {d_mag, 1'b0};
         neg_x_ff  <= num_x_ff[MOM_W-1] ^ den_ff[DEN_W-1];
         neg_y_ff  <= num_y_ff[MOM_W-1] ^ den_ff[DEN_W-1];
      end
      if (cmd.check) begin
         ovf_x_ff <= DVS_W'(nmag_x_ff) >= {dmag_ff, {Q_W{1'b0}}};
         ovf_y_ff <= DVS_W'(nmag_y_ff) >= {dmag_ff, {Q_W{1'b0}}};
         rem_x_ff <= nmag_x_ff;
         rem_y_ff <= nmag_y_ff;
         dsh_ff   <= DVS_W'({dmag_ff, {(Q_W-1){1'b0}}});
         q_x_ff   <= '0;
         q_y_ff   <= '0;
      end else if (cmd.step) begin
         if (ge_x) rem_x_ff <= rem_x_ff - dsh_ff[MAG_W-1:0];
         if (ge_y) rem_y_ff <= rem_y_ff - dsh_ff[MAG_W-1:0];
         q_x_ff <= {q_x_ff[Q_W-2:0], ge_x};
         q_y_ff <= {q_y_ff[Q_W-2:0], ge_y};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   // ---------------- result and output register ----------------
   logic [Q_W-1:0]          qs_x, qs_y;
   logic signed [RES_W-1:0] sq_x, sq_y;
   logic signed [RES_W:0]   sum_x, sum_y;
   logic                    out_v_ff;
   logic [2*COORD_W-1:0]    out_d_ff;
   logic                    out_u_ff;

   assign qs_x  = ovf_x_ff ? '1 : q_x_ff;
   assign qs_y  = ovf_y_ff ? '1 : q_y_ff;
   assign sq_x  = neg_x_ff ? -signed'(RES_W'(qs_x)) : signed'(RES_W'(qs_x));
   assign sq_y  = neg_y_ff ? -signed'(RES_W'(qs_y)) : signed'(RES_W'(qs_y));
   assign sum_x = (RES_W+1)'(sq_x) + (RES_W+1)'(add_x_ff);
   assign sum_y = (RES_W+1)'(sq_y) + (RES_W+1)'(add_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_d_ff <= {sat16(sum_y), sat16(sum_x)};
         out_u_ff <= fb_ff;
      end
   end

   assign stat.out_free = !out_v_ff || rsp_tready;
   assign rsp_tvalid    = out_v_ff;
   assign rsp_tdata     = out_d_ff;
   assign rsp_tuser     = out_u_ff;

endmodule

### design/pcen_checker.sv
// pcen_checker: port-level checks for polygon_centroid_top, bound to it below.
// Uses pcen_pkg.
module pcen_checker import pcen_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 req_tlast,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [2*COORD_W-1:0] rsp_tdata,
   input logic                 rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // last vertex closes the input until the centroid is worked out
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input open right after last vertex");

   // a new result only comes out of the finish phase
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result word without a finished polygon");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind polygon_centroid_top pcen_checker u_pcen_checker (.*);
